FILE: rtl/core/twt_pkg.sv
package twt_pkg;

	localparam int HEIGHT_W = 16;
	localparam int TOTAL_W  = 26;
	localparam int ACC_W    = 27;

	localparam logic [ACC_W-1:0] TOTAL_MAX = ACC_W'((1 << TOTAL_W) - 1);

	localparam int STATE_W = 2;
	localparam logic [STATE_W-1:0] ST_LOAD = 2'd0;
	localparam logic [STATE_W-1:0] ST_PASS = 2'd1;
	localparam logic [STATE_W-1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic [HEIGHT_W-1:0] pmax;
		logic [HEIGHT_W-1:0] height;
	} twt_entry_t;

endpackage

FILE: rtl/core/twt_ram.sv
module twt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/trapped_water_total.sv
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata[15:0] height, s_tlast last
// m        out  m_tvalid/m_tready  m_tdata[25:0] total_water, [26] overflow
//
// a sequence of n stored samples loads at one request per cycle, then a backward
// pass reads the sample memory once per position, from n-1 down to 1, its pace
// set by the single read port of the store
// s_tready is low during the backward pass and until the result has a free slot
// a result waiting on m_tready does not stop loading of the next sequence
// reset clears the control state only; the store needs no clearing
module trapped_water_total
	import twt_pkg::*;
#(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] height
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [25:0] total_water, [26] overflow, [31:27] zero
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

	logic [STATE_W-1:0]  state_q;
	logic [CW-1:0]       count_q;
	logic [HEIGHT_W-1:0] pref_q;
	logic                ovf_q;
	logic [AW-1:0]       rd_ptr_q;
	logic                issue_q;
	logic                rd_vld_s1;
	logic                rd_last_s1;
	logic [HEIGHT_W-1:0] suf_q;
	logic [ACC_W-1:0]    acc_q;
	logic                out_vld_q;
	logic [TOTAL_W-1:0]  out_total_q;
	logic                out_ovf_q;

	logic                in_acc;
	logic                room;
	logic [HEIGHT_W-1:0] h_in;
	logic [HEIGHT_W-1:0] pref_new;
	logic [CW-1:0]       count_new;
	twt_entry_t          wr_entry;
	twt_entry_t          rd_entry;
	logic                ram_re;
	logic [HEIGHT_W-1:0] suf_new;
	logic [HEIGHT_W-1:0] lim;
	logic [ACC_W-1:0]    sum;
	logic                slot_free;

	assign s_tready  = (state_q == ST_LOAD);
	assign in_acc    = s_tvalid && s_tready;
	assign h_in      = s_tdata;
	assign room      = (count_q < CNT_MAX);
	assign pref_new  = ((count_q == '0) || (h_in > pref_q)) ? h_in : pref_q;
	assign count_new = room ? count_q + CW'(1) : count_q;
	assign wr_entry  = '{pmax: pref_new, height: h_in};
	assign ram_re    = (state_q == ST_PASS) && issue_q;
	assign slot_free = !out_vld_q || m_tready;

	twt_ram #(
		.WIDTH($bits(twt_entry_t)),
		.DEPTH(MAX_SAMPLES)
	) u_store (
		.clk  (clk),
		.we   (in_acc && room),
		.waddr(count_q[AW-1:0]),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(rd_ptr_q),
		.rdata(rd_entry)
	);

	// suffix max, water level and saturating sum for the returned entry
	always_comb begin
		suf_new = (rd_entry.height > suf_q) ? rd_entry.height : suf_q;
		lim     = (rd_entry.pmax < suf_new) ? rd_entry.pmax : suf_new;
		sum     = acc_q;
		if (lim > rd_entry.height) begin
			sum = acc_q + ACC_W'(lim - rd_entry.height);
		end
		if (sum > TOTAL_MAX) begin
			sum = TOTAL_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			pref_q     <= '0;
			ovf_q      <= 1'b0;
			rd_ptr_q   <= '0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			suf_q      <= '0;
			acc_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && slot_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			rd_vld_s1  <= ram_re;
			rd_last_s1 <= ram_re && (rd_ptr_q == AW'(1));
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						count_q <= count_new;
						if (room) begin
							pref_q <= pref_new;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							suf_q <= '0;
							acc_q <= '0;
							if (count_new < CW'(3)) begin
								state_q <= ST_DONE;
							end else begin
								rd_ptr_q <= AW'(count_new - CW'(1));
								issue_q  <= 1'b1;
								state_q  <= ST_PASS;
							end
						end
					end
				end
				ST_PASS: begin
					if (ram_re) begin
						rd_ptr_q <= rd_ptr_q - AW'(1);
						if (rd_ptr_q == AW'(1)) begin
							issue_q <= 1'b0;
						end
					end
					if (rd_vld_s1) begin
						suf_q <= suf_new;
						acc_q <= sum;
						if (rd_last_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						count_q   <= '0;
						pref_q    <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && slot_free) begin
			out_total_q <= acc_q[TOTAL_W-1:0];
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_ovf_q, out_total_q};

	a_rd_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_PASS))
		else $error("memory data returned outside the backward pass");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("sample count beyond store depth");

	a_issue_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (rd_ptr_q != '0))
		else $error("backward pass reads the first position");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && slot_free) |=> (m_tvalid && (state_q == ST_LOAD)))
		else $error("result not presented after the pass");

	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= TOTAL_MAX)
		else $error("accumulator above saturation limit");

endmodule

FILE: bench/tb.sv
module tb;
	import twt_pkg::*;

	localparam int SAMPLE_DEPTH = 1024;
	localparam int RANDOM_ITEMS = 550;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 40;
	localparam int CYCLE_LIMIT  = 500000;

	typedef enum {MIX_FULL, MIX_LOW, MIX_EDGE} height_mix_t;

	class water_scoreboard #(int DEPTH = 1024);
		logic [HEIGHT_W-1:0] heights[$];
		logic [HEIGHT_W-1:0] peaks[$];
		bit                  dropped;
		logic [TOTAL_W-1:0]  want_total[$];
		bit                  want_ovf[$];
		int                  errors;

		// backward walk with running right-side max
		function logic [TOTAL_W-1:0] trapped_sum();
			logic [ACC_W-1:0]    acc;
			logic [HEIGHT_W-1:0] right_max;
			logic [HEIGHT_W-1:0] lim;
			int                  n;
			n = heights.size();
			acc = '0;
			if (n < 3)
				return '0;
			right_max = heights[n-1];
			for (int i = n - 2; i >= 1; i--) begin
				if (heights[i] > right_max)
					right_max = heights[i];
				lim = (peaks[i] < right_max) ? peaks[i] : right_max;
				if (lim > heights[i])
					acc = acc + ACC_W'(lim - heights[i]);
				if (acc > TOTAL_MAX)
					acc = TOTAL_MAX;
			end
			return acc[TOTAL_W-1:0];
		endfunction

		function void note_sample(logic [HEIGHT_W-1:0] h, logic lst);
			logic [HEIGHT_W-1:0] peak;
			if (heights.size() < DEPTH) begin
				if (heights.size() == 0)
					peak = h;
				else if (h > peaks[$])
					peak = h;
				else
					peak = peaks[$];
				heights.push_back(h);
				peaks.push_back(peak);
			end else begin
				dropped = 1'b1;
			end
			if (lst) begin
				want_total.push_back(trapped_sum());
				want_ovf.push_back(dropped);
				heights.delete();
				peaks.delete();
				dropped = 1'b0;
			end
		endfunction

		function void check_result(logic [31:0] d);
			logic [TOTAL_W-1:0] t;
			bit                 o;
			if (want_total.size() == 0) begin
				$error("unexpected result: total_water %0d overflow %0d",
					d[TOTAL_W-1:0], d[TOTAL_W]);
				errors++;
				return;
			end
			t = want_total.pop_front();
			o = want_ovf.pop_front();
			if (d[TOTAL_W-1:0] !== t) begin
				$error("total_water expected %0d actual %0d", t, d[TOTAL_W-1:0]);
				errors++;
			end
			if (d[TOTAL_W] !== o) begin
				$error("overflow expected %0d actual %0d", o, d[TOTAL_W]);
				errors++;
			end
		endfunction

		function int pending();
			return want_total.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	water_scoreboard #(SAMPLE_DEPTH) sb = new;
	logic [HEIGHT_W-1:0] run_q[$];
	bit                  no_idle;
	bit                  hold_results;
	int                  cycles;

	trapped_water_total #(.MAX_SAMPLES(SAMPLE_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** trapped_water_total: FAILED **");
			$finish;
		end
	end

	// handshakes are settled by the falling edge and complete at the next rising one
	always @(negedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_sample(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	function automatic logic [HEIGHT_W-1:0] draw_height(height_mix_t mix);
		case (mix)
			MIX_LOW:  return HEIGHT_W'($urandom_range(0, 15));
			MIX_EDGE: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			default:  return HEIGHT_W'($urandom());
		endcase
	endfunction

	task automatic send_sample(input logic [HEIGHT_W-1:0] h, input logic lst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= h;
		s_tlast  <= lst;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic send_run();
		for (int i = 0; i < run_q.size(); i++)
			send_sample(run_q[i], i == run_q.size() - 1);
	endtask

	task automatic send_random_run(input int len);
		height_mix_t mix;
		mix = height_mix_t'($urandom_range(0, 2));
		run_q.delete();
		repeat (len)
			run_q.push_back(draw_height(mix));
		send_run();
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// result side
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid)
				@(negedge clk);
			@(posedge clk);
		end
	end

	initial begin
		int sent;
		int len;
		int pick;
		int seq;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short runs, ridges, valleys and a textbook profile
		run_q = '{16'hFFFF};
		send_run();
		run_q = '{16'h0000, 16'hFFFF};
		send_run();
		run_q = '{16'hFFFF, 16'h0000, 16'hFFFF};
		send_run();
		run_q = '{16'h0000, 16'hFFFF, 16'h0000};
		send_run();
		run_q = '{16'd4, 16'd0, 16'd2, 16'd0, 16'd4};
		send_run();
		run_q = '{16'd0, 16'd1, 16'd0, 16'd2, 16'd1, 16'd0,
			16'd1, 16'd3, 16'd2, 16'd1, 16'd2};
		send_run();
		wait_drained();

		// full store at the largest total, then an overrun that drops the last five samples
		no_idle = 1'b1;
		run_q.delete();
		run_q.push_back('1);
		repeat (SAMPLE_DEPTH - 2) run_q.push_back('0);
		run_q.push_back('1);
		repeat (5) run_q.push_back(draw_height(MIX_LOW));
		send_run();
		no_idle = 1'b0;
		send_random_run(4);
		wait_drained();

		// result side held off while short runs pile up
		hold_results = 1'b1;
		no_idle = 1'b1;
		repeat (12) send_random_run(3);
		no_idle = 1'b0;
		wait_drained();

		sent = 0;
		seq = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ((seq / 6) % 4) == 3;
			pick = $urandom_range(0, 99);
			if (pick < 8)
				len = $urandom_range(1, 2);
			else if (pick < 90)
				len = $urandom_range(3, 12);
			else
				len = $urandom_range(13, 48);
			send_random_run(len);
			sent += len;
			seq++;
			if (seq == 40)
				wait_drained();
		end
		no_idle = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("** trapped_water_total: PASSED **");
		else
			$display("** trapped_water_total: FAILED **");
		$finish;
	end

endmodule
